// ----- hw/rtl/mst_and_second_best_cost_assert.svh -----
// Assertion macros for the spanning tree cost block.
// Both expect clk_i and rst_ni in the scope of use.
`ifndef MST_AND_SECOND_BEST_COST_ASSERT_SVH
`define MST_AND_SECOND_BEST_COST_ASSERT_SVH

// Same-cycle implication.
`define MSTSB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mstsb check failed");

// Next-cycle implication.
`define MSTSB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mstsb check failed");

`endif

// ----- hw/rtl/mstsb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mstsb_pkg;

  localparam int MAX_VERTICES_DEF = 128;
  localparam int MAX_EDGES_DEF    = 4096;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int VID_W       = 7;
  localparam int WIN_W       = 16;
  localparam int VC_W        = 8;
  localparam int COST_W      = 23;
  localparam int RANK_W      = 3;
  localparam int RANK_MAX    = 7;
  localparam int VC_RESET    = 2;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_EDGE       = 2'd0,
    CMD_CLOSE      = 2'd1,
    CMD_EDGE_CLOSE = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [VID_W-1:0] from_v;
    logic [VID_W-1:0] to_v;
    logic [WIN_W-1:0] weight;
  } cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mst_and_second_best_cost.sv -----
// Minimum spanning tree and second-best spanning tree cost engine. Edges stream in one per
// transfer and land in the edge store at one per cycle while the back end is idle; a transfer
// with last_edge_i closes the graph and yields one result, all other transfers yield none.
// Edges past MAX_EDGES are dropped and flagged in edge_overflow_o. After the closing transfer
// the back end sorts the edges with a bottom-up merge sort over two ping-pong key memories,
// then runs Kruskal passes through a union-find memory: one pass for the tree and one more per
// tree edge, each pass ending once the tree is complete or the edges run out. While the back
// end works, the two-entry command queue keeps taking transfers until it fills. The user must
// write vertex_count via cfg_we_i only between graphs; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module mst_and_second_best_cost #(
  parameter int MAX_VERTICES = mstsb_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = mstsb_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = mstsb_pkg::WEIGHT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mstsb_pkg::VC_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         edge_present_i,
  input  logic [mstsb_pkg::VID_W-1:0]  from_vertex_i,
  input  logic [mstsb_pkg::VID_W-1:0]  to_vertex_i,
  input  logic [mstsb_pkg::WIN_W-1:0]  edge_weight_i,
  input  logic                         last_edge_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mstsb_pkg::COST_W-1:0] mst_cost_o,
  output logic                         mst_found_o,
  output logic [mstsb_pkg::COST_W-1:0] second_cost_o,
  output logic                         second_found_o,
  output logic                         edge_overflow_o
);
  import mstsb_pkg::*;

  cmd_t push_data, pop_data;
  logic push, pop, q_full, q_empty;

  mstsb_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .edge_present_i (edge_present_i),
    .from_vertex_i  (from_vertex_i),
    .to_vertex_i    (to_vertex_i),
    .edge_weight_i  (edge_weight_i),
    .last_edge_i    (last_edge_i),
    .q_full_i       (q_full),
    .q_push_o       (push),
    .q_data_o       (push_data)
  );

  mstsb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (pop_data),
    .empty_o (q_empty)
  );

  mstsb_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (pop_data),
    .cmd_empty_i     (q_empty),
    .cmd_pop_o       (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mst_cost_o      (mst_cost_o),
    .mst_found_o     (mst_found_o),
    .second_cost_o   (second_cost_o),
    .second_found_o  (second_found_o),
    .edge_overflow_o (edge_overflow_o)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/mstsb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mstsb_front (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          edge_present_i,
  input  logic [mstsb_pkg::VID_W-1:0]   from_vertex_i,
  input  logic [mstsb_pkg::VID_W-1:0]   to_vertex_i,
  input  logic [mstsb_pkg::WIN_W-1:0]   edge_weight_i,
  input  logic                          last_edge_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output mstsb_pkg::cmd_t               q_data_o
);
  import mstsb_pkg::*;

  assign in_stall_o = q_full_i;
  // empty items that do not close a graph are taken and dropped here
  assign q_push_o = in_valid_i && !q_full_i && (edge_present_i || last_edge_i);

  always_comb begin
    q_data_o.from_v = from_vertex_i;
    q_data_o.to_v   = to_vertex_i;
    q_data_o.weight = edge_weight_i;
    priority if (edge_present_i && last_edge_i) q_data_o.kind = CMD_EDGE_CLOSE;
    else if (edge_present_i)                    q_data_o.kind = CMD_EDGE;
    else                                        q_data_o.kind = CMD_CLOSE;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mstsb_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mstsb_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mstsb_pkg::cmd_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output mstsb_pkg::cmd_t data_o,
  output logic            empty_o
);
  import mstsb_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [NW-1:0] cnt_q, cnt_d;

  assign full_o  = (32'(cnt_q) == QUEUE_DEPTH);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) wp_d = (32'(wp_q) == QUEUE_DEPTH - 1) ? '0 : wp_q + PW'(1);
    if (pop_i)  rp_d = (32'(rp_q) == QUEUE_DEPTH - 1) ? '0 : rp_q + PW'(1);
    if (push_i && !pop_i)      cnt_d = cnt_q + NW'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - NW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mstsb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mstsb_back #(
  parameter int MAX_VERTICES = mstsb_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = mstsb_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = mstsb_pkg::WEIGHT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mstsb_pkg::VC_W-1:0]   cfg_wdata_i,
  input  mstsb_pkg::cmd_t              cmd_i,
  input  logic                         cmd_empty_i,
  output logic                         cmd_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mstsb_pkg::COST_W-1:0] mst_cost_o,
  output logic                         mst_found_o,
  output logic [mstsb_pkg::COST_W-1:0] second_cost_o,
  output logic                         second_found_o,
  output logic                         edge_overflow_o
);
  import mstsb_pkg::*;

  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int EW = CW + 2;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int KW = WEIGHT_BITS + AW;
  localparam int SW = WEIGHT_BITS + VW;
  localparam int UW = RANK_W + VW;

  typedef enum logic [19:0] {
    ST_IDLE       = 20'h00001,
    ST_SORT_INIT  = 20'h00002,
    ST_SORT_SETUP = 20'h00004,
    ST_M_RDP      = 20'h00008,
    ST_M_RDQ      = 20'h00010,
    ST_M_HQ       = 20'h00020,
    ST_M_OUT      = 20'h00040,
    ST_M_FILL     = 20'h00080,
    ST_K_INIT     = 20'h00100,
    ST_K_NEXT     = 20'h00200,
    ST_K_KEY      = 20'h00400,
    ST_K_EDGE     = 20'h00800,
    ST_F_WAIT     = 20'h01000,
    ST_C_WAIT     = 20'h02000,
    ST_U1         = 20'h04000,
    ST_U2         = 20'h08000,
    ST_K_END      = 20'h10000,
    ST_T_RD       = 20'h20000,
    ST_T_WAIT     = 20'h40000,
    ST_DONE       = 20'h80000
  } state_e;

  // control
  state_e                 state_q, state_d;
  logic [VC_W-1:0]        vc_q, vc_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic                   src_q, src_d;
  logic                   skip_en_q, skip_en_d;
  logic                   mst_found_q, mst_found_d;
  logic                   best_v_q, best_v_d;
  logic [MAX_VERTICES-1:0] pv_q;
  logic                   pv_clr;

  // datapath
  logic [EW-1:0]          width_q, width_d, lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
  logic [EW-1:0]          p_q, p_d, q_q, q_d, k_q, k_d;
  logic [KW-1:0]          hp_q, hp_d, hq_q, hq_d;
  logic                   fq_q, fq_d;
  logic [CW-1:0]          i_q, i_d;
  logic [AW-1:0]          e_q, e_d, skip_q, skip_d;
  logic [WEIGHT_BITS-1:0] w_q, w_d;
  logic [NW-1:0]          joined_q, joined_d, tree_cnt_q, tree_cnt_d, t_q, t_d;
  logic [SW-1:0]          sum_q, sum_d, mst_q, mst_d, best_q, best_d;
  logic [VW-1:0]          v_q, v_d, to_q, to_d, root_q, root_d, ra_q, ra_d;
  logic [RANK_W-1:0]      rroot_q, rroot_d, rka_q, rka_d;
  logic                   side_q, side_d;

  // memories
  logic [2*VID_W-1:0] es_mem [MAX_EDGES];
  logic [KW-1:0]      buf0_mem [MAX_EDGES];
  logic [KW-1:0]      buf1_mem [MAX_EDGES];
  logic [UW-1:0]      uf_mem [MAX_VERTICES];
  logic [AW-1:0]      tr_mem [MAX_VERTICES];

  logic               es_we;
  logic [AW-1:0]      es_wa, es_ra;
  logic [2*VID_W-1:0] es_wd, es_rd_q;
  logic               buf_we, buf_wsel;
  logic [AW-1:0]      buf_wa, buf_ra;
  logic [KW-1:0]      buf_wd, rd0_q, rd1_q, rd_key;
  logic               uf_we, uf_rv_q;
  logic [VW-1:0]      uf_wa, uf_ra, uf_ra_q, uf_par;
  logic [UW-1:0]      uf_wd, uf_rd_q;
  logic [RANK_W-1:0]  uf_rank;
  logic               tr_we;
  logic [VW-1:0]      tr_wa, tr_ra;
  logic [AW-1:0]      tr_wd, tr_rd_q;

  logic [NW-1:0]      n_w;
  logic [EW-1:0]      cnt_e;
  logic               p_ok, q_ok, take_q, swap, found;
  logic [VW-1:0]      child, newroot;
  logic [RANK_W-1:0]  rk_c, rk_n;
  logic [VID_W-1:0]   es_from, es_to;

  assign n_w     = (32'(vc_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vc_q);
  assign cnt_e   = EW'(cnt_q);
  assign rd_key  = src_q ? rd1_q : rd0_q;
  assign uf_par  = uf_rv_q ? uf_rd_q[VW-1:0] : uf_ra_q;
  assign uf_rank = uf_rv_q ? uf_rd_q[VW +: RANK_W] : '0;
  assign es_from = es_rd_q[2*VID_W-1:VID_W];
  assign es_to   = es_rd_q[VID_W-1:0];
  assign p_ok    = (p_q < mid_q);
  assign q_ok    = (q_q < hi_q);
  // keys are {weight, index}: unique, so ties fall to arrival order
  assign take_q  = q_ok && (!p_ok || (hq_q < hp_q));
  assign swap    = (rka_q > rroot_q);
  assign child   = swap ? root_q : ra_q;
  assign newroot = swap ? ra_q : root_q;
  assign rk_c    = swap ? rroot_q : rka_q;
  assign rk_n    = swap ? rka_q : rroot_q;
  assign found   = (n_w != '0) && (joined_q == n_w - NW'(1));

  always_comb begin
    state_d     = state_q;
    vc_d        = cfg_we_i ? cfg_wdata_i : vc_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    src_d       = src_q;
    skip_en_d   = skip_en_q;
    mst_found_d = mst_found_q;
    best_v_d    = best_v_q;
    width_d     = width_q;
    lo_d        = lo_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    p_d         = p_q;
    q_d         = q_q;
    k_d         = k_q;
    hp_d        = hp_q;
    hq_d        = hq_q;
    fq_d        = fq_q;
    i_d         = i_q;
    e_d         = e_q;
    skip_d      = skip_q;
    w_d         = w_q;
    joined_d    = joined_q;
    tree_cnt_d  = tree_cnt_q;
    t_d         = t_q;
    sum_d       = sum_q;
    mst_d       = mst_q;
    best_d      = best_q;
    v_d         = v_q;
    to_d        = to_q;
    root_d      = root_q;
    rroot_d     = rroot_q;
    ra_d        = ra_q;
    rka_d       = rka_q;
    side_d      = side_q;
    cmd_pop_o   = 1'b0;
    pv_clr      = 1'b0;
    es_we       = 1'b0;
    es_wa       = '0;
    es_wd       = '0;
    es_ra       = '0;
    buf_we      = 1'b0;
    buf_wsel    = 1'b0;
    buf_wa      = '0;
    buf_wd      = '0;
    buf_ra      = '0;
    uf_we       = 1'b0;
    uf_wa       = '0;
    uf_wd       = '0;
    uf_ra       = '0;
    tr_we       = 1'b0;
    tr_wa       = '0;
    tr_wd       = '0;
    tr_ra       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind != CMD_CLOSE) begin
            if (32'(cnt_q) < MAX_EDGES) begin
              es_we  = 1'b1;
              es_wa  = cnt_q[AW-1:0];
              es_wd  = {cmd_i.from_v, cmd_i.to_v};
              buf_we = 1'b1;
              buf_wa = cnt_q[AW-1:0];
              buf_wd = {WEIGHT_BITS'(cmd_i.weight), cnt_q[AW-1:0]};
              cnt_d  = cnt_q + CW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (cmd_i.kind != CMD_EDGE) state_d = ST_SORT_INIT;
        end
      end
      ST_SORT_INIT: begin
        width_d  = EW'(1);
        lo_d     = '0;
        src_d    = 1'b0;
        best_v_d = 1'b0;
        best_d   = '0;
        state_d  = ST_SORT_SETUP;
      end
      ST_SORT_SETUP: begin
        priority if (width_q >= cnt_e) begin
          skip_en_d = 1'b0;
          state_d   = ST_K_INIT;
        end else if (lo_q >= cnt_e) begin
          width_d = width_q << 1;
          src_d   = !src_q;
          lo_d    = '0;
        end else begin
          mid_d   = (lo_q + width_q > cnt_e) ? cnt_e : lo_q + width_q;
          hi_d    = (lo_q + (width_q << 1) > cnt_e) ? cnt_e : lo_q + (width_q << 1);
          p_d     = lo_q;
          q_d     = (lo_q + width_q > cnt_e) ? cnt_e : lo_q + width_q;
          k_d     = lo_q;
          state_d = ST_M_RDP;
        end
      end
      ST_M_RDP: begin
        buf_ra  = p_q[AW-1:0];
        state_d = ST_M_RDQ;
      end
      ST_M_RDQ: begin
        hp_d    = rd_key;
        buf_ra  = q_q[AW-1:0];
        state_d = ST_M_HQ;
      end
      ST_M_HQ: begin
        hq_d    = rd_key;
        state_d = ST_M_OUT;
      end
      ST_M_OUT: begin
        if (!p_ok && !q_ok) begin
          lo_d    = hi_q;
          state_d = ST_SORT_SETUP;
        end else begin
          buf_we   = 1'b1;
          buf_wsel = !src_q;
          buf_wa   = k_q[AW-1:0];
          buf_wd   = take_q ? hq_q : hp_q;
          k_d      = k_q + EW'(1);
          fq_d     = take_q;
          if (take_q) begin
            q_d    = q_q + EW'(1);
            buf_ra = AW'(q_q + EW'(1));
          end else begin
            p_d    = p_q + EW'(1);
            buf_ra = AW'(p_q + EW'(1));
          end
          state_d = ST_M_FILL;
        end
      end
      ST_M_FILL: begin
        if (fq_q) hq_d = rd_key;
        else      hp_d = rd_key;
        state_d = ST_M_OUT;
      end
      ST_K_INIT: begin
        pv_clr   = 1'b1;
        sum_d    = '0;
        joined_d = '0;
        i_d      = '0;
        state_d  = ST_K_NEXT;
      end
      ST_K_NEXT: begin
        // a full tree joins nothing more, so the pass can stop early
        if (i_q >= cnt_q || found) begin
          state_d = ST_K_END;
        end else begin
          buf_ra  = i_q[AW-1:0];
          state_d = ST_K_KEY;
        end
      end
      ST_K_KEY: begin
        e_d = rd_key[AW-1:0];
        w_d = rd_key[AW +: WEIGHT_BITS];
        if (skip_en_q && rd_key[AW-1:0] == skip_q) begin
          i_d     = i_q + CW'(1);
          state_d = ST_K_NEXT;
        end else begin
          es_ra   = rd_key[AW-1:0];
          state_d = ST_K_EDGE;
        end
      end
      ST_K_EDGE: begin
        if (32'(es_from) >= 32'(n_w) || 32'(es_to) >= 32'(n_w)) begin
          i_d     = i_q + CW'(1);
          state_d = ST_K_NEXT;
        end else begin
          v_d     = VW'(es_from);
          to_d    = VW'(es_to);
          side_d  = 1'b0;
          uf_ra   = VW'(es_from);
          state_d = ST_F_WAIT;
        end
      end
      ST_F_WAIT: begin
        if (uf_par == uf_ra_q) begin
          root_d  = uf_ra_q;
          rroot_d = uf_rank;
          uf_ra   = v_q;
          state_d = ST_C_WAIT;
        end else begin
          uf_ra = uf_par;
        end
      end
      ST_C_WAIT: begin
        // second walk: point every node on the path straight at the root
        if (uf_par == root_q) begin
          if (!side_q) begin
            ra_d    = root_q;
            rka_d   = rroot_q;
            side_d  = 1'b1;
            v_d     = to_q;
            uf_ra   = to_q;
            state_d = ST_F_WAIT;
          end else begin
            state_d = ST_U1;
          end
        end else begin
          uf_we = 1'b1;
          uf_wa = uf_ra_q;
          uf_wd = {uf_rank, root_q};
          uf_ra = uf_par;
        end
      end
      ST_U1: begin
        if (ra_q == root_q) begin
          i_d     = i_q + CW'(1);
          state_d = ST_K_NEXT;
        end else begin
          uf_we    = 1'b1;
          uf_wa    = child;
          uf_wd    = {rk_c, newroot};
          sum_d    = sum_q + SW'(w_q);
          joined_d = joined_q + NW'(1);
          if (!skip_en_q) begin
            tr_we = 1'b1;
            tr_wa = joined_q[VW-1:0];
            tr_wd = e_q;
          end
          ra_d  = newroot;
          rka_d = rk_n;
          if (rk_c == rk_n && 32'(rk_n) < RANK_MAX) begin
            state_d = ST_U2;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = ST_K_NEXT;
          end
        end
      end
      ST_U2: begin
        uf_we   = 1'b1;
        uf_wa   = ra_q;
        uf_wd   = {rka_q + RANK_W'(1), ra_q};
        i_d     = i_q + CW'(1);
        state_d = ST_K_NEXT;
      end
      ST_K_END: begin
        if (!skip_en_q) begin
          mst_d       = sum_q;
          mst_found_d = found;
          tree_cnt_d  = joined_q;
          t_d         = '0;
          state_d     = (found && joined_q != '0) ? ST_T_RD : ST_DONE;
        end else begin
          if (found && (!best_v_q || sum_q < best_q)) begin
            best_d   = sum_q;
            best_v_d = 1'b1;
          end
          t_d     = t_q + NW'(1);
          state_d = (t_q + NW'(1) < tree_cnt_q) ? ST_T_RD : ST_DONE;
        end
      end
      ST_T_RD: begin
        tr_ra   = t_q[VW-1:0];
        state_d = ST_T_WAIT;
      end
      ST_T_WAIT: begin
        skip_d    = tr_rd_q;
        skip_en_d = 1'b1;
        state_d   = ST_K_INIT;
      end
      ST_DONE: begin
        if (!out_stall_i) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vc_q        <= VC_W'(VC_RESET);
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      src_q       <= 1'b0;
      skip_en_q   <= 1'b0;
      mst_found_q <= 1'b0;
      best_v_q    <= 1'b0;
      pv_q        <= '0;
    end else begin
      state_q     <= state_d;
      vc_q        <= vc_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      src_q       <= src_d;
      skip_en_q   <= skip_en_d;
      mst_found_q <= mst_found_d;
      best_v_q    <= best_v_d;
      if (pv_clr)     pv_q        <= '0;
      else if (uf_we) pv_q[uf_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    width_q    <= width_d;
    lo_q       <= lo_d;
    mid_q      <= mid_d;
    hi_q       <= hi_d;
    p_q        <= p_d;
    q_q        <= q_d;
    k_q        <= k_d;
    hp_q       <= hp_d;
    hq_q       <= hq_d;
    fq_q       <= fq_d;
    i_q        <= i_d;
    e_q        <= e_d;
    skip_q     <= skip_d;
    w_q        <= w_d;
    joined_q   <= joined_d;
    tree_cnt_q <= tree_cnt_d;
    t_q        <= t_d;
    sum_q      <= sum_d;
    mst_q      <= mst_d;
    best_q     <= best_d;
    v_q        <= v_d;
    to_q       <= to_d;
    root_q     <= root_d;
    rroot_q    <= rroot_d;
    ra_q       <= ra_d;
    rka_q      <= rka_d;
    side_q     <= side_d;
  end

  always_ff @(posedge clk_i) begin
    if (es_we) es_mem[es_wa] <= es_wd;
    es_rd_q <= es_mem[es_ra];
  end

  always_ff @(posedge clk_i) begin
    if (buf_we && !buf_wsel) buf0_mem[buf_wa] <= buf_wd;
    rd0_q <= buf0_mem[buf_ra];
  end

  always_ff @(posedge clk_i) begin
    if (buf_we && buf_wsel) buf1_mem[buf_wa] <= buf_wd;
    rd1_q <= buf1_mem[buf_ra];
  end

  // entries without a valid bit read as their own root, rank zero
  always_ff @(posedge clk_i) begin
    if (uf_we) uf_mem[uf_wa] <= uf_wd;
    uf_rd_q <= uf_mem[uf_ra];
    uf_rv_q <= pv_q[uf_ra];
    uf_ra_q <= uf_ra;
  end

  always_ff @(posedge clk_i) begin
    if (tr_we) tr_mem[tr_wa] <= tr_wd;
    tr_rd_q <= tr_mem[tr_ra];
  end

  assign out_valid_o     = (state_q == ST_DONE);
  assign mst_found_o     = mst_found_q;
  assign mst_cost_o      = mst_found_q ? COST_W'(mst_q) : '0;
  assign second_found_o  = best_v_q;
  assign second_cost_o   = best_v_q ? COST_W'(best_q) : '0;
  assign edge_overflow_o = ovf_q;

endmodule
`default_nettype wire

// ----- hw/rtl/mstsb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "mst_and_second_best_cost_assert.svh"
module mstsb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [mstsb_pkg::COST_W-1:0] mst_cost_o,
  input logic                         mst_found_o,
  input logic [mstsb_pkg::COST_W-1:0] second_cost_o,
  input logic                         second_found_o
);

  `MSTSB_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `MSTSB_ASSERT_NXT(a_cost_hold, out_valid_o && out_stall_i, $stable(second_cost_o))
  `MSTSB_ASSERT_IMP(a_no_tree, out_valid_o && !mst_found_o, !second_found_o && mst_cost_o == '0)
  `MSTSB_ASSERT_IMP(a_second_ge, out_valid_o && second_found_o, second_cost_o >= mst_cost_o)

endmodule

bind mst_and_second_best_cost mstsb_checker u_chk (.*);
`default_nettype wire

// ----- tb/mst_and_second_best_cost_checker.sv -----
`timescale 1ns / 1ps
module mst_and_second_best_cost_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mstsb_pkg::VC_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         edge_present_i,
  input  logic [mstsb_pkg::VID_W-1:0]  from_vertex_i,
  input  logic [mstsb_pkg::VID_W-1:0]  to_vertex_i,
  input  logic [mstsb_pkg::WIN_W-1:0]  edge_weight_i,
  input  logic                         last_edge_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [mstsb_pkg::COST_W-1:0] mst_cost_i,
  input  logic                         mst_found_i,
  input  logic [mstsb_pkg::COST_W-1:0] second_cost_i,
  input  logic                         second_found_i,
  input  logic                         edge_overflow_i,
  output int                           error_count_o,
  output int                           pending_o
);
  import mstsb_pkg::*;

  localparam int MAX_V = MAX_VERTICES_DEF;
  localparam int MAX_E = MAX_EDGES_DEF;

  typedef struct {
    logic [COST_W-1:0] mst_cost;
    logic              mst_found;
    logic [COST_W-1:0] second_cost;
    logic              second_found;
    logic              edge_overflow;
  } cost_result_t;

  cost_result_t      expected_costs[$];
  logic [VC_W-1:0]   vertices;
  logic [VID_W-1:0]  ep_from[MAX_E];
  logic [VID_W-1:0]  ep_to[MAX_E];
  logic [WIN_W-1:0]  ep_weight[MAX_E];
  int                ep_count;
  logic              dropped;
  int                by_weight[MAX_E];
  int                tree_list[$];

  function automatic int root_of(ref int parent[MAX_V], input int v);
    int r;
    int nxt;
    r = v;
    while (parent[r] != r) r = parent[r];
    while (parent[v] != r) begin
      nxt = parent[v];
      parent[v] = r;
      v = nxt;
    end
    return r;
  endfunction

  // One Kruskal pass skipping edge 'skip' (-1 for none).
  function automatic bit spans(int n, int skip, bit keep_tree, output longint cost);
    int parent[MAX_V];
    int joined;
    int ra;
    int rb;
    int e;
    joined = 0;
    cost = 0;
    for (int i = 0; i < MAX_V; i++) parent[i] = i;
    if (keep_tree) tree_list.delete();
    for (int i = 0; i < ep_count; i++) begin
      e = by_weight[i];
      if (e == skip || ep_from[e] >= n || ep_to[e] >= n) continue;
      ra = root_of(parent, ep_from[e]);
      rb = root_of(parent, ep_to[e]);
      if (ra == rb) continue;
      parent[ra] = rb;
      cost += ep_weight[e];
      if (keep_tree) tree_list.insert(tree_list.size(), e);
      joined++;
    end
    return n > 0 && joined == n - 1;
  endfunction

  function automatic void close_graph();
    cost_result_t r;
    int n;
    int key;
    int j;
    longint cost;
    longint alt;
    longint best;
    bit have_alt;
    n = (vertices > MAX_V) ? MAX_V : vertices;
    // stable insertion sort: ties stay in arrival order
    for (int i = 0; i < ep_count; i++) begin
      key = i;
      j = i - 1;
      while (j >= 0 && ep_weight[by_weight[j]] > ep_weight[key]) begin
        by_weight[j+1] = by_weight[j];
        j--;
      end
      by_weight[j+1] = key;
    end
    r.mst_found = spans(n, -1, 1'b1, cost);
    r.mst_cost = r.mst_found ? cost[COST_W-1:0] : '0;
    have_alt = 1'b0;
    best = 0;
    if (r.mst_found) begin
      foreach (tree_list[k]) begin
        if (spans(n, tree_list[k], 1'b0, alt)) begin
          if (!have_alt || alt < best) best = alt;
          have_alt = 1'b1;
        end
      end
    end
    r.second_found = have_alt;
    r.second_cost = have_alt ? best[COST_W-1:0] : '0;
    r.edge_overflow = dropped;
    expected_costs.insert(expected_costs.size(), r);
    ep_count = 0;
    dropped = 1'b0;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    cost_result_t exp_r;
    if (!rst_ni) begin
      error_count_o = 0;
      pending_o = 0;
      vertices = VC_W'(VC_RESET);
      ep_count = 0;
      dropped = 1'b0;
    end else begin
      if (cfg_we_i) vertices = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        if (edge_present_i) begin
          if (ep_count < MAX_E) begin
            ep_from[ep_count] = from_vertex_i;
            ep_to[ep_count] = to_vertex_i;
            ep_weight[ep_count] = edge_weight_i;
            ep_count++;
          end else begin
            dropped = 1'b1;
          end
        end
        if (last_edge_i) close_graph();
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_costs.size() == 0) begin
          $error("result transfer with no graph closed");
          error_count_o++;
        end else begin
          exp_r = expected_costs.pop_front();
          check_field("mst_cost", exp_r.mst_cost, mst_cost_i);
          check_field("mst_found", exp_r.mst_found, mst_found_i);
          check_field("second_cost", exp_r.second_cost, second_cost_i);
          check_field("second_found", exp_r.second_found, second_found_i);
          check_field("edge_overflow", exp_r.edge_overflow, edge_overflow_i);
        end
      end
      pending_o = expected_costs.size();
    end
  end

endmodule

// ----- tb/mst_and_second_best_cost_tb.sv -----
`timescale 1ns / 1ps
module mst_and_second_best_cost_tb;
  import mstsb_pkg::*;

  localparam int STALL_LIMIT = 2000000;
  localparam int SETTLE      = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [VC_W-1:0]     cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                edge_present_i = 1'b0;
  logic [VID_W-1:0]    from_vertex_i = '0;
  logic [VID_W-1:0]    to_vertex_i = '0;
  logic [WIN_W-1:0]    edge_weight_i = '0;
  logic                last_edge_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [COST_W-1:0]   mst_cost_o;
  logic                mst_found_o;
  logic [COST_W-1:0]   second_cost_o;
  logic                second_found_o;
  logic                edge_overflow_o;
  int                  error_count;
  int                  pending;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int cur_vertices = VC_RESET;
  int big_left = 2;
  int quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  mst_and_second_best_cost dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .edge_present_i, .from_vertex_i, .to_vertex_i, .edge_weight_i, .last_edge_i,
    .out_valid_o, .out_stall_i, .mst_cost_o, .mst_found_o, .second_cost_o,
    .second_found_o, .edge_overflow_o
  );

  mst_and_second_best_cost_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_i(in_stall_o),
    .edge_present_i, .from_vertex_i, .to_vertex_i, .edge_weight_i, .last_edge_i,
    .out_valid_i(out_valid_o), .out_stall_i, .mst_cost_i(mst_cost_o),
    .mst_found_i(mst_found_o), .second_cost_i(second_cost_o),
    .second_found_i(second_found_o), .edge_overflow_i(edge_overflow_o),
    .error_count_o(error_count), .pending_o(pending)
  );

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("mst_and_second_best_cost_tb: errors");
          $finish;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(bit present, int src, int dst, int weight, bit close);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    edge_present_i <= present;
    from_vertex_i <= VID_W'(src);
    to_vertex_i <= VID_W'(dst);
    edge_weight_i <= WIN_W'(weight);
    last_edge_i <= close;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic set_vertices(int value);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= VC_W'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_vertices = value;
  endtask

  function automatic int pick_vertex(int cap);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
    return $urandom_range(0, cap - 1);
  endfunction

  function automatic int pick_weight();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 7);
    return $urandom_range(0, 65535);
  endfunction

  // Optional spanning path first so most graphs reach the exclusion passes.
  task automatic send_graph(int extras, bit tidy);
    int cap;
    int a;
    int b;
    cap = (cur_vertices < 1) ? 1 : (cur_vertices > 128 ? 128 : cur_vertices);
    if (tidy) begin
      for (int k = 1; k < cap; k++) begin
        send_item(1'b1, k, $urandom_range(0, k - 1), pick_weight(), 1'b0);
      end
    end
    for (int k = 0; k < extras; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(1'b0, $urandom_range(0, 127), $urandom_range(0, 127),
                  $urandom_range(0, 65535), 1'b0);
      end
      a = pick_vertex(cap);
      b = ($urandom_range(0, 14) == 0) ? a : pick_vertex(cap);
      send_item(1'b1, a, b, pick_weight(), 1'b0);
    end
    send_item($urandom_range(0, 1), pick_vertex(cap), pick_vertex(cap), pick_weight(), 1'b1);
  endtask

  task automatic random_phase(int target);
    int choice;
    int nv;
    target += items_sent;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        choice = $urandom_range(0, 19);
        if (choice == 0) nv = 0;
        else if (choice == 1) nv = 255;
        else if (choice == 2 && big_left > 0) nv = 128;
        else nv = $urandom_range(1, 12);
        if (nv >= 128) begin
          if (big_left > 0) big_left--;
          else nv = 12;
        end
        set_vertices(nv);
      end
      send_graph((cur_vertices >= 128) ? 40 : $urandom_range(0, 16),
                 $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset vertex count, heaviest edge
    send_item(1'b1, 0, 1, 65535, 1'b1);
    // single vertex, empty closing item
    set_vertices(1);
    send_item(1'b0, 0, 0, 0, 1'b1);
    // zero vertices: never a tree
    set_vertices(0);
    send_item(1'b1, 0, 0, 5, 1'b1);
    // count above the maximum saturates; top vertex ids, disconnected graph
    set_vertices(255);
    send_item(1'b1, 127, 126, 0, 1'b0);
    send_item(1'b1, 127, 127, 65535, 1'b1);
    // triangle with ties, self loop, out-of-range endpoint, empty item
    set_vertices(3);
    send_item(1'b1, 0, 1, 4, 1'b0);
    send_item(1'b1, 1, 2, 4, 1'b0);
    send_item(1'b0, 127, 127, 65535, 1'b0);
    send_item(1'b1, 2, 2, 0, 1'b0);
    send_item(1'b1, 0, 3, 1, 1'b0);
    send_item(1'b1, 2, 0, 4, 1'b0);
    send_item(1'b1, 0, 2, 9, 1'b1);
    // tree only: no alternative
    send_item(1'b1, 0, 1, 2, 1'b0);
    send_item(1'b1, 1, 2, 3, 1'b1);
    // max vertices with a path of heaviest edges
    set_vertices(128);
    for (int k = 1; k < 128; k++) send_item(1'b1, k, k - 1, 65535, 1'b0);
    send_item(1'b1, 127, 0, 65535, 1'b1);

    send_idle_pct = 25;
    recv_stall_pct = 56;
    random_phase(350);

    send_idle_pct = 56;
    recv_stall_pct = 25;
    random_phase(350);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_vertices(3);
    random_phase(350);
    set_vertices(2);
    send_graph(4, 1'b1);

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    if (error_count == 0) begin
      $display("mst_and_second_best_cost_tb: clean");
    end else begin
      $display("mst_and_second_best_cost_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/mstsb_pkg.sv
hw/rtl/mstsb_front.sv
hw/rtl/mstsb_fifo.sv
hw/rtl/mstsb_back.sv
hw/rtl/mst_and_second_best_cost.sv
hw/rtl/mstsb_checker.sv
tb/mst_and_second_best_cost_checker.sv
tb/mst_and_second_best_cost_tb.sv
